FILE: sv/playfair_stream_encrypt_macros.svh
// ----------------------------------------------------------------------------
// playfair stream encrypt assertion macros
// shared property wrappers for the clocked checks in the rtl
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_STREAM_ENCRYPT_MACROS_SVH
`define PLAYFAIR_STREAM_ENCRYPT_MACROS_SVH

// checked outside reset only
`define PLF_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PLF_ASSERT_ALL(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// letter codes, job and pair types, and key square position helpers
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int SIDE = 5;
  localparam int CELLS = SIDE * SIDE;
  localparam int ALPHA = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] pos_t;
  typedef logic [2:0] coord_t;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_X = 5'd23;
  localparam letter_t LAST_CODE = 5'(ALPHA - 1);
  localparam pos_t LAST_POS = 5'(CELLS - 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  localparam logic JOB_LOAD = 1'b0;
  localparam logic JOB_PAIR = 1'b1;

  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // load job: l0 = letter, l1 = position; pair job: (l0,l1) and (l2,l3)
  typedef struct packed {
    logic    kind;
    logic    two_pairs;
    logic    final_msg;
    letter_t l0;
    letter_t l1;
    letter_t l2;
    letter_t l3;
  } job_t;

  typedef struct packed {
    letter_t let0;
    letter_t let1;
    logic    final_msg;
  } pair_t;

  function automatic coord_t pos_row(pos_t p);
    coord_t r;
    if (p >= 5'(4 * SIDE)) r = 3'd4;
    else if (p >= 5'(3 * SIDE)) r = 3'd3;
    else if (p >= 5'(2 * SIDE)) r = 3'd2;
    else if (p >= 5'(SIDE)) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic pos_t pos_at(coord_t r, coord_t c);
    return 5'({r, 2'b00}) + 5'(r) + 5'(c);
  endfunction

  function automatic coord_t pos_col(pos_t p);
    pos_t d;
    d = p - pos_at(pos_row(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic coord_t wrap_inc(coord_t x);
    return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

FILE: sv/plf_prep.sv
// ----------------------------------------------------------------------------
// plf_prep
// message preparation: j to i, x between doubled letters, x pad at the
// end, pairing into jobs; load requests pass through as load jobs
// ----------------------------------------------------------------------------
module plf_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           op,
  input  logic [4:0]     position,
  input  logic [4:0]     letter,
  input  logic           last,
  output logic           push,
  output plf_pkg::job_t  job
);

  plf_pkg::letter_t held_letter;
  logic             held_valid;
  plf_pkg::letter_t pair_first;
  logic             pair_first_valid;

  plf_pkg::letter_t let_n;
  plf_pkg::letter_t chain [4];
  logic [2:0]       len;
  logic             load_ok;
  logic             pair_ready;

  always_comb begin
    let_n = (letter > plf_pkg::LAST_CODE) ? plf_pkg::CODE_X : letter;
    if (let_n == plf_pkg::CODE_J) let_n = plf_pkg::CODE_I;

    for (int k = 0; k < 4; k++) chain[k] = plf_pkg::CODE_X;
    len = 3'd0;
    if (pair_first_valid) begin
      chain[len[1:0]] = pair_first;
      len = len + 3'd1;
    end
    if (held_valid) begin
      chain[len[1:0]] = held_letter;
      len = len + 3'd1;
      if (held_letter == let_n) begin
        chain[len[1:0]] = plf_pkg::CODE_X;
        len = len + 3'd1;
      end
    end
    if (last) begin
      chain[len[1:0]] = let_n;
      len = len + 3'd1;
      // odd prepared text gets an x pad
      if (len[0]) begin
        chain[len[1:0]] = plf_pkg::CODE_X;
        len = len + 3'd1;
      end
    end
  end

  assign load_ok = (position <= plf_pkg::LAST_POS) && (letter <= plf_pkg::LAST_CODE);
  assign pair_ready = len[2] | len[1];

  always_comb begin
    job.final_msg = last;
    if (op == plf_pkg::OP_LOAD) begin
      job.kind = plf_pkg::JOB_LOAD;
      job.two_pairs = 1'b0;
      job.l0 = letter;
      job.l1 = position;
      job.l2 = chain[2];
      job.l3 = chain[3];
      push = accept & load_ok;
    end else begin
      job.kind = plf_pkg::JOB_PAIR;
      job.two_pairs = len[2];
      job.l0 = chain[0];
      job.l1 = chain[1];
      job.l2 = chain[2];
      job.l3 = chain[3];
      push = accept & pair_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid <= 1'b0;
      pair_first <= '0;
      pair_first_valid <= 1'b0;
    end else if (accept && op == plf_pkg::OP_TEXT) begin
      if (last) begin
        held_valid <= 1'b0;
        pair_first_valid <= 1'b0;
      end else begin
        held_letter <= let_n;
        held_valid <= 1'b1;
        pair_first_valid <= len[0];
        pair_first <= len[1] ? chain[2] : chain[0];
      end
    end
  end

endmodule

FILE: sv/plf_job_fifo.sv
// ----------------------------------------------------------------------------
// plf_job_fifo
// small job queue between preparation and the cipher pipeline
// ----------------------------------------------------------------------------
`include "playfair_stream_encrypt_macros.svh"

module plf_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  plf_pkg::job_t  din,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output plf_pkg::job_t  dout
);

  plf_pkg::job_t                  mem [plf_pkg::JOB_DEPTH];
  logic [plf_pkg::JOB_PTR_W-1:0]  wr_ptr;
  logic [plf_pkg::JOB_PTR_W-1:0]  rd_ptr;
  logic [plf_pkg::JOB_CNT_W-1:0]  count;

  assign full = (count == plf_pkg::JOB_CNT_W'(plf_pkg::JOB_DEPTH));
  assign q_valid = (count != '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  `PLF_ASSERT_CLK(a_push_not_full, push |-> !full, "job push into a full queue")
  `PLF_ASSERT_CLK(a_pop_not_empty, pop |-> q_valid, "job pop from an empty queue")

endmodule

FILE: sv/plf_cipher.sv
// ----------------------------------------------------------------------------
// plf_cipher
// two-stage pair pipeline: position map read, then key square read with
// the row, column and rectangle rules; load jobs write both memories in
// pipeline order
// ----------------------------------------------------------------------------
`include "playfair_stream_encrypt_macros.svh"

module plf_cipher (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  plf_pkg::job_t   head,
  output logic            pop,
  input  logic            out_free,
  output logic            b_valid,
  output plf_pkg::pair_t  b_pair
);

  plf_pkg::pos_t    pos_mem [plf_pkg::ALPHA];
  plf_pkg::letter_t sq_mem [plf_pkg::CELLS];

  logic             sel;
  logic             a_valid;
  logic             a_load;
  logic             a_final;
  plf_pkg::pos_t    a_pos0;
  plf_pkg::pos_t    a_pos1;
  plf_pkg::pos_t    a_wpos;
  plf_pkg::letter_t a_wlet;

  plf_pkg::letter_t b_let0;
  plf_pkg::letter_t b_let1;
  logic             b_final;

  plf_pkg::letter_t pair_l0;
  plf_pkg::letter_t pair_l1;
  logic             is_load;
  logic             job_end;
  logic             dispatch;
  logic             a_move;
  logic             a_free;
  logic             b_move;
  logic             b_free;

  plf_pkg::coord_t  r0, c0, r1, c1;
  plf_pkg::pos_t    addr0, addr1;

  assign pair_l0 = sel ? head.l2 : head.l0;
  assign pair_l1 = sel ? head.l3 : head.l1;
  assign is_load = (head.kind == plf_pkg::JOB_LOAD);
  assign job_end = is_load | ~head.two_pairs | sel;

  assign b_move = b_valid & out_free;
  assign b_free = ~b_valid | b_move;
  // a load leaves stage a without occupying stage b
  assign a_move = a_valid & (a_load | b_free);
  assign a_free = ~a_valid | a_move;
  assign dispatch = q_valid & a_free;
  assign pop = dispatch & job_end;

  assign r0 = plf_pkg::pos_row(a_pos0);
  assign c0 = plf_pkg::pos_col(a_pos0);
  assign r1 = plf_pkg::pos_row(a_pos1);
  assign c1 = plf_pkg::pos_col(a_pos1);

  always_comb begin
    priority if (c0 == c1) begin
      addr0 = plf_pkg::pos_at(plf_pkg::wrap_inc(r0), c0);
      addr1 = plf_pkg::pos_at(plf_pkg::wrap_inc(r1), c1);
    end else if (r0 == r1) begin
      addr0 = plf_pkg::pos_at(r0, plf_pkg::wrap_inc(c0));
      addr1 = plf_pkg::pos_at(r1, plf_pkg::wrap_inc(c1));
    end else begin
      addr0 = plf_pkg::pos_at(r0, c1);
      addr1 = plf_pkg::pos_at(r1, c0);
    end
  end

  // position map port
  always_ff @(posedge clk) begin
    if (dispatch) begin
      if (is_load) begin
        pos_mem[head.l0] <= head.l1;
      end else begin
        a_pos0 <= pos_mem[pair_l0];
        a_pos1 <= pos_mem[pair_l1];
      end
      a_load <= is_load;
      a_final <= head.final_msg & job_end;
      a_wpos <= head.l1;
      a_wlet <= head.l0;
    end
  end

  // key square port
  always_ff @(posedge clk) begin
    if (a_move) begin
      if (a_load) begin
        sq_mem[a_wpos] <= a_wlet;
      end else begin
        b_let0 <= sq_mem[addr0];
        b_let1 <= sq_mem[addr1];
        b_final <= a_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (dispatch) sel <= ~job_end;

      if (dispatch) a_valid <= 1'b1;
      else if (a_move) a_valid <= 1'b0;

      if (a_move && !a_load) b_valid <= 1'b1;
      else if (b_move) b_valid <= 1'b0;
    end
  end

  assign b_pair.let0 = b_let0;
  assign b_pair.let1 = b_let1;
  assign b_pair.final_msg = b_final;

  `PLF_ASSERT_CLK(a_sel_second_pair, sel |-> q_valid && head.kind == plf_pkg::JOB_PAIR && head.two_pairs, "second pair select without a two pair job")
  `PLF_ASSERT_CLK(a_b_hold, b_valid && !out_free |=> b_valid && $stable(b_let0) && $stable(b_let1), "stage b lost a blocked pair")

endmodule

FILE: sv/plf_out.sv
// ----------------------------------------------------------------------------
// plf_out
// result register: takes one enciphered pair and hands out its two
// letters one request at a time
// ----------------------------------------------------------------------------
`include "playfair_stream_encrypt_macros.svh"

module plf_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            b_valid,
  input  plf_pkg::pair_t  b_pair,
  output logic            out_free,
  output logic            res_valid,
  input  logic            res_stall,
  output logic [4:0]      cipher_letter,
  output logic            final_res
);

  logic           out_valid;
  logic           out_idx;
  plf_pkg::pair_t held;
  logic           out_take;
  logic           load_pair;

  assign out_take = out_valid & ~res_stall;
  // a new pair may enter as the second letter leaves
  assign out_free = ~out_valid | (out_idx & out_take);
  assign load_pair = b_valid & out_free;

  always_ff @(posedge clk) begin
    if (load_pair) held <= b_pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_idx <= 1'b0;
    end else if (load_pair) begin
      out_valid <= 1'b1;
      out_idx <= 1'b0;
    end else if (out_take) begin
      if (out_idx) out_valid <= 1'b0;
      else out_idx <= 1'b1;
    end
  end

  assign res_valid = out_valid;
  assign cipher_letter = out_idx ? held.let1 : held.let0;
  assign final_res = out_idx & held.final_msg;

  `PLF_ASSERT_CLK(a_second_follows, out_valid && !out_idx |=> out_valid, "pair dropped before its second letter")
  `PLF_ASSERT_ALL(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

endmodule

FILE: sv/playfair_stream_encrypt.sv
// ----------------------------------------------------------------------------
// playfair_stream_encrypt
// playfair encryption of a letter stream with a loadable 5x5 key square
// ----------------------------------------------------------------------------
// Load requests (op 0) write one key square entry and its letter position;
// text requests (op 1) carry one letter each and produce 0, 2 or 4 cipher
// letters, one per result request, with final_res on the last letter of a
// message. Results leave at one letter per cycle while res_stall is low, from
// a single result register; text requests yield a pair every other request,
// a little over one letter on average with the x fill, and load requests
// make no letters. After the request that completes a pair is accepted,
// the pair passes the job queue write, position map read and key square
// read, then reaches the result register. A four-entry job queue lets
// requests keep arriving while results wait; stall rises only when that
// queue is full.
// The key square and position map need no clearing after reset; load the
// whole square before enciphering.
module playfair_stream_encrypt (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic       op,
  input  logic [4:0] position,
  input  logic [4:0] letter,
  input  logic       last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [4:0] cipher_letter,
  output logic       final_res
);

  logic           accept;
  logic           push;
  plf_pkg::job_t  job;
  logic           full;
  logic           q_valid;
  plf_pkg::job_t  head;
  logic           pop;
  logic           out_free;
  logic           b_valid;
  plf_pkg::pair_t b_pair;

  assign stall = full;
  assign accept = valid & ~stall;

  plf_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (op),
    .position (position),
    .letter   (letter),
    .last     (last),
    .push     (push),
    .job      (job)
  );

  plf_job_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (job),
    .pop     (pop),
    .full    (full),
    .q_valid (q_valid),
    .dout    (head)
  );

  plf_cipher u_cipher (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .out_free (out_free),
    .b_valid  (b_valid),
    .b_pair   (b_pair)
  );

  plf_out u_out (
    .clk           (clk),
    .rst           (rst),
    .b_valid       (b_valid),
    .b_pair        (b_pair),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .cipher_letter (cipher_letter),
    .final_res     (final_res)
  );

endmodule
